### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/icdf_pkg.sv
`default_nettype none

package icdf_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_FRAC_BITS   = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // word index of the registers
   localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

### sv/inverse_cdf_bin_search.sv
// Operation: a write word is taken only while idle; a query makes p probes, with
//   p <= ceil(log2(table_size+1)) (9 at 256 entries), and then shows its result.
// Throughput: one probe a cycle, bound by the two-port table read feeding the
//   compare that picks the next midpoint; a new query waits until busy falls.
// Reset: synchronous, active high; table_size returns to 1, table contents are
//   kept and undefined until written. The result strobe cannot be stalled.
`default_nettype none

module inverse_cdf_bin_search #(
   parameter int TABLE_DEPTH = icdf_pkg::DEF_TABLE_DEPTH,
   parameter int FRAC_BITS   = icdf_pkg::DEF_FRAC_BITS,
   localparam int IDX_W = $clog2(TABLE_DEPTH),
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic                            req_command,
   input  wire logic [IDX_W-1:0]                req_entry_index,
   input  wire logic [FRAC_BITS:0]              req_entry_value,
   input  wire logic [FRAC_BITS-1:0]            req_query_value,

   output      logic                            rsp_valid,
   output      logic [CNT_W-1:0]                rsp_bin_index,

   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [icdf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [icdf_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [icdf_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                            pready
);

   localparam int ENT_W = FRAC_BITS + 1;
   localparam int POS_W = CNT_W + 1;

   typedef enum logic {
      IDLE,
      SEARCH
   } state_type;

   // ---------------- configuration ----------------
   logic [CNT_W-1:0] size_ff, size_in;
   logic             csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[icdf_pkg::CSR_ADDR_W-1:2] == icdf_pkg::REG_TABLE_SIZE);
   assign prdata  = csr_hit ? icdf_pkg::CSR_DATA_W'(size_ff) : '0;

   always_comb begin
      size_in = size_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         size_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CNT_W'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   // size clamped to 1..TABLE_DEPTH
   logic [CNT_W-1:0] n_eff;
   always_comb begin
      if (size_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (size_ff > CNT_W'(TABLE_DEPTH)) begin
         n_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         n_eff = size_ff;
      end
   end

   // ---------------- table memory ----------------
   logic [ENT_W-1:0] cdf_mem [TABLE_DEPTH];
   logic [ENT_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
   logic             wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cdf_mem[req_entry_index] <= req_entry_value;
      end
   end

   // port a reads entry mid-1 (ext[mid]), port b entry mid (ext[mid+1])
   always_ff @(posedge clock) begin
      rd_a_ff <= cdf_mem[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      rd_b_ff <= cdf_mem[rd_addr_b];
   end

   // ---------------- search control ----------------
   state_type           state_ff, state_in;
   logic [POS_W-1:0]    low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic [FRAC_BITS-1:0] query_ff, query_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    rsp_bin_ff, rsp_bin_in;

   logic [ENT_W-1:0]    here, there, u_ext;
   logic                hit, go_right, cont;
   logic [POS_W-1:0]    low_nx, high_nx, probe_mid;

   assign here     = (mid_ff == '0) ? '0 : rd_a_ff;
   assign there    = rd_b_ff;
   assign u_ext    = {1'b0, query_ff};
   assign hit      = (here <= u_ext) && (there > u_ext);
   assign go_right = (here < u_ext);
   assign low_nx   = go_right ? POS_W'(mid_ff + 1'b1) : low_ff;
   assign high_nx  = go_right ? high_ff : POS_W'(mid_ff - 1'b1);
   assign cont     = ($signed(low_nx) <= $signed(high_nx));

   // midpoint of the next probe; both bounds are non-negative whenever it is used
   always_comb begin
      if (state_ff == IDLE) begin
         probe_mid = POS_W'({1'b0, n_eff} - 1'b1) >> 1;
      end else begin
         probe_mid = POS_W'(low_nx + high_nx) >> 1;
      end
   end

   assign rd_addr_b = probe_mid[IDX_W-1:0];
   assign rd_addr_a = IDX_W'(probe_mid - 1'b1);

   assign wr_en = (state_ff == IDLE) && start && (req_command == icdf_pkg::CMD_WRITE)
                  && (CNT_W'(req_entry_index) < CNT_W'(TABLE_DEPTH));

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      query_in     = query_ff;
      rsp_valid_in = 1'b0;
      rsp_bin_in   = rsp_bin_ff;
      case (state_ff)
         IDLE: begin
            if (start && (req_command == icdf_pkg::CMD_QUERY)) begin
               state_in = SEARCH;
               low_in   = '0;
               high_in  = POS_W'({1'b0, n_eff} - 1'b1);
               mid_in   = probe_mid;
               query_in = req_query_value;
            end
         end
         SEARCH: begin
            if (hit) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
               rsp_bin_in   = CNT_W'(mid_ff + 1'b1);
            end else if (!cont) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
               rsp_bin_in   = n_eff;
            end else begin
               low_in  = low_nx;
               high_in = high_nx;
               mid_in  = probe_mid;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff     <= low_in;
      high_ff    <= high_in;
      mid_ff     <= mid_in;
      query_ff   <= query_in;
      rsp_bin_ff <= rsp_bin_in;
   end

   // writes are only taken while no search reads the table
   assign busy          = (state_ff != IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;

   // ---------------- assertions ----------------
`include "assert_macros.svh"

   `ASSERT_IMP(a_bin_range, clock, reset, rsp_valid, (rsp_bin_index != '0) && (rsp_bin_index <= CNT_W'(TABLE_DEPTH)))
   `ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_query_busy, clock, reset, start && !busy && (req_command == icdf_pkg::CMD_QUERY), busy)
   `ASSERT_IMP(a_bounds, clock, reset, busy, ($signed(low_ff) <= $signed(high_ff)) && (mid_ff < POS_W'(TABLE_DEPTH)))

endmodule

`default_nettype wire
